FILE: src/ambient_cancelled_wall_sensor_sequencer_macros.svh
// assertion macros shared by the wall sensor sequencer modules
// no dependencies; included by the modules that carry assertions
`ifndef AMBIENT_CANCELLED_WALL_SENSOR_SEQUENCER_MACROS_SVH
`define AMBIENT_CANCELLED_WALL_SENSOR_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled during reset
`define ACWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("acws assertion failed");

// next-cycle implication, disabled during reset
`define ACWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("acws assertion failed");

`endif

FILE: src/acws_pkg.sv
// types, constants and helper functions of the wall sensor sequencer
// no dependencies; used by every module of the block
`default_nettype none

package acws_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int LIMIT_W     = 12;
    localparam int VAL_W       = LIMIT_W + 1;
    localparam int CHG_W       = 13;
    localparam int DARK_W      = (SAMPLE_BITS < LIMIT_W) ? SAMPLE_BITS : LIMIT_W;
    localparam int DIFF_W      = ((SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W) + 1;
    localparam int VALUE_LIMIT = 4095;
    localparam int IN_DATA_W   = ((4 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 2 + 4 + 4 * VAL_W + 3 + 8 + 2 * CHG_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_W   = 2;

    localparam logic OP_CONV  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FRONT_LEFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_RIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_LEFT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_RIGHT  = 2'd3;

    localparam logic [3:0] DRIVE_OFF   = 4'h0;
    localparam logic [3:0] DRIVE_SIDE  = 4'h9;
    localparam logic [3:0] DRIVE_FRONT = 4'h6;

    localparam logic [7:0] MAP_FRONT_LEFT = 8'h88;
    localparam logic [7:0] MAP_SIDE_RIGHT = 8'h44;
    localparam logic [7:0] MAP_SIDE_LEFT  = 8'h11;

    localparam logic [2:0] FLAG_SIDE_LEFT   = 3'b001;
    localparam logic [2:0] FLAG_SIDE_RIGHT  = 3'b010;
    localparam logic [2:0] FLAG_FRONT_RIGHT = 3'b100;

    typedef enum logic [1:0] {
        PH_DARK  = 2'd0,
        PH_SIDE  = 2'd1,
        PH_FRONT = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef struct packed {
        logic                   op;
        logic [SAMPLE_BITS-1:0] sample_side_left;
        logic [SAMPLE_BITS-1:0] sample_side_right;
        logic [SAMPLE_BITS-1:0] sample_front_left;
        logic [SAMPLE_BITS-1:0] sample_front_right;
    } t_item;

    typedef struct packed {
        logic                    updated;
        logic [CHG_W-1:0]        side_right_change;
        logic [CHG_W-1:0]        side_left_change;
        logic [7:0]              wall_map;
        logic [2:0]              wall_flags;
        logic signed [VAL_W-1:0] side_right_value;
        logic signed [VAL_W-1:0] side_left_value;
        logic signed [VAL_W-1:0] front_right_value;
        logic signed [VAL_W-1:0] front_left_value;
        logic [3:0]              emitter_drive;
        t_phase                  phase_now;
    } t_result;

    // lit minus dark, clamped to the value range
    function automatic logic signed [VAL_W-1:0] lit_minus_dark(
        input logic [SAMPLE_BITS-1:0] lit,
        input logic [DARK_W-1:0]      dark
    );
        logic signed [DIFF_W-1:0] d;
        logic signed [DIFF_W-1:0] lim_p;
        logic signed [DIFF_W-1:0] lim_n;
        lim_p = DIFF_W'(VALUE_LIMIT);
        lim_n = -lim_p;
        d = $signed({{(DIFF_W-SAMPLE_BITS){1'b0}}, lit})
          - $signed({{(DIFF_W-DARK_W){1'b0}}, dark});
        if (d > lim_p) begin
            d = lim_p;
        end else if (d < lim_n) begin
            d = lim_n;
        end
        return VAL_W'(d);
    endfunction

    function automatic logic [CHG_W-1:0] abs_diff(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0] d;
        d = $signed({a[VAL_W-1], a}) - $signed({b[VAL_W-1], b});
        if (d < 0) begin
            d = -d;
        end
        return CHG_W'(d);
    endfunction

    // negative values never reach an unsigned limit
    function automatic logic at_or_above(
        input logic signed [VAL_W-1:0] value,
        input logic [LIMIT_W-1:0]      limit
    );
        return !value[VAL_W-1] && (value[LIMIT_W-1:0] >= limit);
    endfunction

    function automatic logic above(
        input logic signed [VAL_W-1:0] value,
        input logic [LIMIT_W-1:0]      limit
    );
        return !value[VAL_W-1] && (value[LIMIT_W-1:0] > limit);
    endfunction

endpackage

`default_nettype wire

FILE: src/acws_in_reg.sv
// input register stage: unpacks the request stream into an item
// depends on acws_pkg
`default_nettype none

module acws_in_reg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [acws_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    input  wire logic                           i_s_axis_tuser,
    input  wire logic                           i_next_ready,
    output logic                                o_valid,
    output acws_pkg::t_item                     o_item
);

    logic            r_valid;
    acws_pkg::t_item r_item;
    acws_pkg::t_item n_item;
    logic            w_accept;

    assign o_s_axis_tready = !r_valid || i_next_ready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_item.op                 = i_s_axis_tuser;
        n_item.sample_front_right = i_s_axis_tdata[acws_pkg::SAMPLE_BITS-1:0];
        n_item.sample_front_left  = i_s_axis_tdata[2*acws_pkg::SAMPLE_BITS-1 -: acws_pkg::SAMPLE_BITS];
        n_item.sample_side_right  = i_s_axis_tdata[3*acws_pkg::SAMPLE_BITS-1 -: acws_pkg::SAMPLE_BITS];
        n_item.sample_side_left   = i_s_axis_tdata[4*acws_pkg::SAMPLE_BITS-1 -: acws_pkg::SAMPLE_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_next_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

FILE: src/acws_core.sv
// phase sequencer, dark store, wall values and wall update logic
// depends on acws_pkg and the assertion macros header
`default_nettype none
`include "ambient_cancelled_wall_sensor_sequencer_macros.svh"

module acws_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [acws_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [acws_pkg::LIMIT_W-1:0]       i_cfg_data,
    input  wire logic                               i_adv,
    input  wire acws_pkg::t_item                    i_item,
    output acws_pkg::t_result                       o_res
);

    logic [acws_pkg::LIMIT_W-1:0] r_lim_fl, r_lim_fr, r_lim_sl, r_lim_sr;

    acws_pkg::t_phase r_phase, n_phase;
    logic [acws_pkg::DARK_W-1:0] r_dark_fr, r_dark_fl, r_dark_sr, r_dark_sl;
    logic [acws_pkg::DARK_W-1:0] n_dark_fr, n_dark_fl, n_dark_sr, n_dark_sl;
    logic signed [acws_pkg::VAL_W-1:0] r_val_fl, r_val_fr, r_val_sl, r_val_sr;
    logic signed [acws_pkg::VAL_W-1:0] n_val_fl, n_val_fr, n_val_sl, n_val_sr;
    logic signed [acws_pkg::VAL_W-1:0] r_prev_sl, r_prev_sr, n_prev_sl, n_prev_sr;
    logic [acws_pkg::CHG_W-1:0] r_chg_sl, r_chg_sr, n_chg_sl, n_chg_sr;
    logic [2:0] r_flags, n_flags;
    logic       w_updated;
    logic [3:0] w_drive;
    logic [7:0] w_map;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_fl <= '0;
            r_lim_fr <= '0;
            r_lim_sl <= '0;
            r_lim_sr <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                acws_pkg::REG_FRONT_LEFT:  r_lim_fl <= i_cfg_data;
                acws_pkg::REG_FRONT_RIGHT: r_lim_fr <= i_cfg_data;
                acws_pkg::REG_SIDE_LEFT:   r_lim_sl <= i_cfg_data;
                acws_pkg::REG_SIDE_RIGHT:  r_lim_sr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_dark_fr = r_dark_fr;
        n_dark_fl = r_dark_fl;
        n_dark_sr = r_dark_sr;
        n_dark_sl = r_dark_sl;
        n_val_fl  = r_val_fl;
        n_val_fr  = r_val_fr;
        n_val_sl  = r_val_sl;
        n_val_sr  = r_val_sr;
        n_prev_sl = r_prev_sl;
        n_prev_sr = r_prev_sr;
        n_chg_sl  = r_chg_sl;
        n_chg_sr  = r_chg_sr;
        n_flags   = r_flags;
        w_updated = 1'b0;
        if (i_item.op == acws_pkg::OP_CONV) begin
            case (r_phase)
                acws_pkg::PH_DARK: begin
                    n_dark_fr = i_item.sample_front_right[acws_pkg::DARK_W-1:0];
                    n_dark_fl = i_item.sample_front_left[acws_pkg::DARK_W-1:0];
                    n_dark_sr = i_item.sample_side_right[acws_pkg::DARK_W-1:0];
                    n_dark_sl = i_item.sample_side_left[acws_pkg::DARK_W-1:0];
                    n_phase   = acws_pkg::PH_SIDE;
                end
                acws_pkg::PH_SIDE: begin
                    n_val_sr = acws_pkg::lit_minus_dark(i_item.sample_side_right, r_dark_sr);
                    n_val_sl = acws_pkg::lit_minus_dark(i_item.sample_side_left, r_dark_sl);
                    n_phase  = acws_pkg::PH_FRONT;
                end
                acws_pkg::PH_FRONT: begin
                    n_val_fr = acws_pkg::lit_minus_dark(i_item.sample_front_right, r_dark_fr);
                    n_val_fl = acws_pkg::lit_minus_dark(i_item.sample_front_left, r_dark_fl);
                    n_phase  = acws_pkg::PH_DONE;
                end
                default: ;
            endcase
        end else if (r_phase == acws_pkg::PH_DONE) begin
            n_phase   = acws_pkg::PH_DARK;
            w_updated = 1'b1;
            n_chg_sr  = acws_pkg::abs_diff(r_val_sr, r_prev_sr);
            n_chg_sl  = acws_pkg::abs_diff(r_val_sl, r_prev_sl);
            n_flags   = '0;
            if (acws_pkg::at_or_above(r_val_sl, r_lim_sl)) begin
                n_flags = n_flags | acws_pkg::FLAG_SIDE_LEFT;
            end
            if (acws_pkg::at_or_above(r_val_sr, r_lim_sr)) begin
                n_flags = n_flags | acws_pkg::FLAG_SIDE_RIGHT;
            end
            if (acws_pkg::at_or_above(r_val_fr, r_lim_fr)) begin
                n_flags = n_flags | acws_pkg::FLAG_FRONT_RIGHT;
            end
            n_prev_sr = r_val_sr;
            n_prev_sl = r_val_sl;
        end

        case (n_phase)
            acws_pkg::PH_SIDE:  w_drive = acws_pkg::DRIVE_SIDE;
            acws_pkg::PH_FRONT: w_drive = acws_pkg::DRIVE_FRONT;
            default:            w_drive = acws_pkg::DRIVE_OFF;
        endcase

        // map uses strict compare on the values after this item
        w_map = '0;
        if (acws_pkg::above(n_val_fl, r_lim_fl)) begin
            w_map = w_map | acws_pkg::MAP_FRONT_LEFT;
        end
        if (acws_pkg::above(n_val_sr, r_lim_sr)) begin
            w_map = w_map | acws_pkg::MAP_SIDE_RIGHT;
        end
        if (acws_pkg::above(n_val_sl, r_lim_sl)) begin
            w_map = w_map | acws_pkg::MAP_SIDE_LEFT;
        end

        o_res.phase_now         = n_phase;
        o_res.emitter_drive     = w_drive;
        o_res.front_left_value  = n_val_fl;
        o_res.front_right_value = n_val_fr;
        o_res.side_left_value   = n_val_sl;
        o_res.side_right_value  = n_val_sr;
        o_res.wall_flags        = n_flags;
        o_res.wall_map          = w_map;
        o_res.side_left_change  = n_chg_sl;
        o_res.side_right_change = n_chg_sr;
        o_res.updated           = w_updated;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= acws_pkg::PH_DARK;
        end else if (i_adv) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark_fr <= '0;
            r_dark_fl <= '0;
            r_dark_sr <= '0;
            r_dark_sl <= '0;
            r_val_fl  <= '0;
            r_val_fr  <= '0;
            r_val_sl  <= '0;
            r_val_sr  <= '0;
            r_prev_sl <= '0;
            r_prev_sr <= '0;
            r_chg_sl  <= '0;
            r_chg_sr  <= '0;
            r_flags   <= '0;
        end else if (i_adv) begin
            r_dark_fr <= n_dark_fr;
            r_dark_fl <= n_dark_fl;
            r_dark_sr <= n_dark_sr;
            r_dark_sl <= n_dark_sl;
            r_val_fl  <= n_val_fl;
            r_val_fr  <= n_val_fr;
            r_val_sl  <= n_val_sl;
            r_val_sr  <= n_val_sr;
            r_prev_sl <= n_prev_sl;
            r_prev_sr <= n_prev_sr;
            r_chg_sl  <= n_chg_sl;
            r_chg_sr  <= n_chg_sr;
            r_flags   <= n_flags;
        end
    end

    `ACWS_ASSERT_NOW(a_update_only_when_done, i_clk, i_rst_n,
        i_adv && o_res.updated,
        r_phase == acws_pkg::PH_DONE && i_item.op == acws_pkg::OP_CHECK)
    `ACWS_ASSERT_NEXT(a_conv_in_done_ignored, i_clk, i_rst_n,
        i_adv && i_item.op == acws_pkg::OP_CONV && r_phase == acws_pkg::PH_DONE,
        r_phase == acws_pkg::PH_DONE && $stable(r_val_fl) && $stable(r_val_sr))
    `ACWS_ASSERT_NEXT(a_state_holds_when_idle, i_clk, i_rst_n,
        !i_adv,
        $stable(r_phase) && $stable(r_flags) && $stable(r_prev_sl))

endmodule

`default_nettype wire

FILE: src/acws_out_reg.sv
// result register stage: holds one result and packs the result stream
// depends on acws_pkg and the assertion macros header
`default_nettype none
`include "ambient_cancelled_wall_sensor_sequencer_macros.svh"

module acws_out_reg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_load,
    input  wire acws_pkg::t_result                i_res,
    output logic                                  o_ready,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic [acws_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    output logic                                  o_m_axis_tuser
);

    logic              r_valid;
    acws_pkg::t_result r_res;

    assign o_ready = !r_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tuser  = r_res.updated;
    assign o_m_axis_tdata  = {
        {(acws_pkg::OUT_DATA_W - acws_pkg::OUT_BITS){1'b0}},
        r_res.side_right_change,
        r_res.side_left_change,
        r_res.wall_map,
        r_res.wall_flags,
        r_res.side_right_value,
        r_res.side_left_value,
        r_res.front_right_value,
        r_res.front_left_value,
        r_res.emitter_drive,
        r_res.phase_now
    };

    `ACWS_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, i_load, r_valid)
    `ACWS_ASSERT_NOW(a_no_load_over_pending, i_clk, i_rst_n,
        i_load && r_valid, i_m_axis_tready)

endmodule

`default_nettype wire

FILE: src/ambient_cancelled_wall_sensor_sequencer.sv
// ambient-cancelled wall sensor sequencer, top level
// a request accepted into the input register is processed by the combinational phase and
// wall update logic and its result is loaded into the result register; throughput one
// request per cycle while the result stream is not stalled
// reset (synchronous, active low) empties both stages, clears limits and all sensor state
// depends on acws_pkg, acws_in_reg, acws_core and acws_out_reg
`default_nettype none

module ambient_cancelled_wall_sensor_sequencer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [acws_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [acws_pkg::LIMIT_W-1:0]    i_cfg_data,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // sample_front_right, sample_front_left, sample_side_right, sample_side_left
    input  wire logic [acws_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // operation
    input  wire logic                            i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // phase_now, emitter_drive, front_left_value, front_right_value, side_left_value,
    // side_right_value, wall_flags, wall_map, side_left_change, side_right_change
    output logic [acws_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // updated
    output logic                                 o_m_axis_tuser
);

    logic              w_item_valid;
    acws_pkg::t_item   w_item;
    logic              w_out_ready;
    logic              w_adv;
    acws_pkg::t_result w_res;

    assign w_adv = w_item_valid && w_out_ready;

    acws_in_reg u_in_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_next_ready    (w_out_ready),
        .o_valid         (w_item_valid),
        .o_item          (w_item)
    );

    acws_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_adv       (w_adv),
        .i_item      (w_item),
        .o_res       (w_res)
    );

    acws_out_reg u_out_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_adv),
        .i_res           (w_res),
        .o_ready         (w_out_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

FILE: tb/tb_ambient_cancelled_wall_sensor_sequencer.sv
// self-checking testbench for the ambient-cancelled wall sensor sequencer
// drives sample and tick requests, predicts every result and compares it field by field
// depends on acws_pkg and ambient_cancelled_wall_sensor_sequencer
`default_nettype none

module tb_ambient_cancelled_wall_sensor_sequencer;

    localparam int SAMPLE_MAX    = (1 << acws_pkg::SAMPLE_BITS) - 1;
    localparam int STALL_LIMIT   = 3000;
    localparam int ITEMS_PER_SET = 70;
    localparam int LIMIT_SETS    = 5;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [acws_pkg::CFG_IDX_W-1:0]   i_cfg_index = acws_pkg::REG_FRONT_LEFT;
    logic [acws_pkg::LIMIT_W-1:0]     i_cfg_data = '0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    // sample_front_right, sample_front_left, sample_side_right, sample_side_left
    logic [acws_pkg::IN_DATA_W-1:0]   i_s_axis_tdata = '0;
    // operation
    logic                             i_s_axis_tuser = acws_pkg::OP_CONV;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    // phase_now, emitter_drive, front_left_value, front_right_value, side_left_value,
    // side_right_value, wall_flags, wall_map, side_left_change, side_right_change
    logic [acws_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata;
    // updated
    logic                             o_m_axis_tuser;

    ambient_cancelled_wall_sensor_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predicted sequencer state
    acws_pkg::t_phase seq_phase = acws_pkg::PH_DARK;
    int      dark_lvl [4];   // channel order: front right, front left, side right, side left
    int      lvl_front_left, lvl_front_right, lvl_side_left, lvl_side_right;
    int      prev_side_left, prev_side_right;
    int      chg_side_left, chg_side_right;
    logic [2:0] flags_now;
    int      lim_front_left, lim_front_right, lim_side_left, lim_side_right;

    acws_pkg::t_result pending_readings [$];
    int      error_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      quiet_cycles = 0;

    initial begin
        for (int k = 0; k < 4; k++) begin
            dark_lvl[k] = 0;
        end
        lvl_front_left = 0;
        lvl_front_right = 0;
        lvl_side_left = 0;
        lvl_side_right = 0;
        prev_side_left = 0;
        prev_side_right = 0;
        chg_side_left = 0;
        chg_side_right = 0;
        flags_now = '0;
        lim_front_left = 0;
        lim_front_right = 0;
        lim_side_left = 0;
        lim_side_right = 0;
    end

    function automatic int cancel_ambient(input logic [acws_pkg::SAMPLE_BITS-1:0] lit,
                                          input int dark);
        int d;
        d = int'(lit) - dark;
        if (d > acws_pkg::VALUE_LIMIT) begin
            d = acws_pkg::VALUE_LIMIT;
        end else if (d < -acws_pkg::VALUE_LIMIT) begin
            d = -acws_pkg::VALUE_LIMIT;
        end
        return d;
    endfunction

    function automatic int magnitude(input int d);
        return (d < 0) ? -d : d;
    endfunction

    // advances the predicted sequencer by one request and returns the reading it gives
    function automatic acws_pkg::t_result advance_sequencer(
        input logic                             op,
        input logic [acws_pkg::SAMPLE_BITS-1:0] fr,
        input logic [acws_pkg::SAMPLE_BITS-1:0] fl,
        input logic [acws_pkg::SAMPLE_BITS-1:0] sr,
        input logic [acws_pkg::SAMPLE_BITS-1:0] sl
    );
        acws_pkg::t_result r;
        r = '0;
        if (op == acws_pkg::OP_CONV) begin
            case (seq_phase)
                acws_pkg::PH_DARK: begin
                    dark_lvl[0] = int'(fr);
                    dark_lvl[1] = int'(fl);
                    dark_lvl[2] = int'(sr);
                    dark_lvl[3] = int'(sl);
                    seq_phase = acws_pkg::PH_SIDE;
                end
                acws_pkg::PH_SIDE: begin
                    lvl_side_right = cancel_ambient(sr, dark_lvl[2]);
                    lvl_side_left = cancel_ambient(sl, dark_lvl[3]);
                    seq_phase = acws_pkg::PH_FRONT;
                end
                acws_pkg::PH_FRONT: begin
                    lvl_front_right = cancel_ambient(fr, dark_lvl[0]);
                    lvl_front_left = cancel_ambient(fl, dark_lvl[1]);
                    seq_phase = acws_pkg::PH_DONE;
                end
                default: begin
                    // conversion after the front phase is dropped
                end
            endcase
        end else if (seq_phase == acws_pkg::PH_DONE) begin
            seq_phase = acws_pkg::PH_DARK;
            r.updated = 1'b1;
            chg_side_right = magnitude(lvl_side_right - prev_side_right);
            chg_side_left = magnitude(lvl_side_left - prev_side_left);
            flags_now = '0;
            if (lvl_side_left >= lim_side_left) begin
                flags_now |= acws_pkg::FLAG_SIDE_LEFT;
            end
            if (lvl_side_right >= lim_side_right) begin
                flags_now |= acws_pkg::FLAG_SIDE_RIGHT;
            end
            if (lvl_front_right >= lim_front_right) begin
                flags_now |= acws_pkg::FLAG_FRONT_RIGHT;
            end
            prev_side_right = lvl_side_right;
            prev_side_left = lvl_side_left;
        end

        r.phase_now = seq_phase;
        case (seq_phase)
            acws_pkg::PH_SIDE:  r.emitter_drive = acws_pkg::DRIVE_SIDE;
            acws_pkg::PH_FRONT: r.emitter_drive = acws_pkg::DRIVE_FRONT;
            default:            r.emitter_drive = acws_pkg::DRIVE_OFF;
        endcase
        r.front_left_value = acws_pkg::VAL_W'(lvl_front_left);
        r.front_right_value = acws_pkg::VAL_W'(lvl_front_right);
        r.side_left_value = acws_pkg::VAL_W'(lvl_side_left);
        r.side_right_value = acws_pkg::VAL_W'(lvl_side_right);
        r.wall_flags = flags_now;
        r.wall_map = '0;
        if (lvl_front_left > lim_front_left) begin
            r.wall_map |= acws_pkg::MAP_FRONT_LEFT;
        end
        if (lvl_side_right > lim_side_right) begin
            r.wall_map |= acws_pkg::MAP_SIDE_RIGHT;
        end
        if (lvl_side_left > lim_side_left) begin
            r.wall_map |= acws_pkg::MAP_SIDE_LEFT;
        end
        r.side_left_change = acws_pkg::CHG_W'(chg_side_left);
        r.side_right_change = acws_pkg::CHG_W'(chg_side_right);
        return r;
    endfunction

    task automatic send_item(
        input logic                             op,
        input logic [acws_pkg::SAMPLE_BITS-1:0] fr,
        input logic [acws_pkg::SAMPLE_BITS-1:0] fl,
        input logic [acws_pkg::SAMPLE_BITS-1:0] sr,
        input logic [acws_pkg::SAMPLE_BITS-1:0] sl
    );
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= op;
        i_s_axis_tdata <= {sl, sr, fl, fr};
        do begin
            @(posedge i_clk);
        end while (!(i_rst_n && o_s_axis_tready));
        pending_readings.push_back(advance_sequencer(op, fr, fl, sr, sl));
    endtask

    // the block never holds a request without a result, so an empty queue means idle
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic drive_limit(input logic [acws_pkg::CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= acws_pkg::LIMIT_W'(value);
        @(posedge i_clk);
    endtask

    task automatic load_limits(input int fl, input int fr, input int sl, input int sr);
        drive_limit(acws_pkg::REG_FRONT_LEFT, fl);
        drive_limit(acws_pkg::REG_FRONT_RIGHT, fr);
        drive_limit(acws_pkg::REG_SIDE_LEFT, sl);
        drive_limit(acws_pkg::REG_SIDE_RIGHT, sr);
        i_cfg_we <= 1'b0;
        lim_front_left = fl;
        lim_front_right = fr;
        lim_side_left = sl;
        lim_side_right = sr;
    endtask

    // mostly random, sometimes an extreme, often just around dark plus limit
    function automatic logic [acws_pkg::SAMPLE_BITS-1:0] pick_sample(input int dark,
                                                                     input int limit);
        int v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = SAMPLE_MAX;
            2, 3, 4: v = dark + limit - 1 + int'($urandom_range(0, 2));
            default: v = int'($urandom_range(0, SAMPLE_MAX));
        endcase
        if (v < 0) begin
            v = 0;
        end else if (v > SAMPLE_MAX) begin
            v = SAMPLE_MAX;
        end
        return acws_pkg::SAMPLE_BITS'(v);
    endfunction

    function automatic logic [acws_pkg::SAMPLE_BITS-1:0] any_sample();
        return acws_pkg::SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
    endfunction

    // ticks outside the done phase and a conversion in it must change nothing
    task automatic test_ignored_items();
        send_item(acws_pkg::OP_CHECK, 12'h123, 12'h456, 12'h789, 12'hABC);
        send_item(acws_pkg::OP_CONV, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_item(acws_pkg::OP_CHECK, 12'h000, 12'h000, 12'h000, 12'h000);
        send_item(acws_pkg::OP_CONV, 12'hFFF, 12'hFFF, 12'h000, 12'h000);
        send_item(acws_pkg::OP_CHECK, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_item(acws_pkg::OP_CONV, 12'h000, 12'h000, 12'hFFF, 12'hFFF);
        send_item(acws_pkg::OP_CONV, 12'h5A5, 12'hA5A, 12'h5A5, 12'hA5A);
        // negative values never reach even a zero limit
        send_item(acws_pkg::OP_CHECK, 12'h000, 12'h000, 12'h000, 12'h000);
    endtask

    task automatic test_value_extremes();
        send_item(acws_pkg::OP_CONV, 12'h000, 12'h000, 12'h000, 12'h000);
        send_item(acws_pkg::OP_CONV, 12'h000, 12'h000, 12'hFFF, 12'hFFF);
        send_item(acws_pkg::OP_CONV, 12'hFFF, 12'hFFF, 12'h000, 12'h000);
        // full swing from the negative extreme on both sides
        send_item(acws_pkg::OP_CHECK, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_item(acws_pkg::OP_CONV, 12'h555, 12'h555, 12'h555, 12'h555);
        send_item(acws_pkg::OP_CONV, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA);
        send_item(acws_pkg::OP_CONV, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA);
        send_item(acws_pkg::OP_CHECK, 12'h555, 12'hAAA, 12'h555, 12'hAAA);
    endtask

    // values exactly at each limit, one below the front right and side limits, one above front left
    task automatic test_limit_boundaries();
        drain_results();
        load_limits(12'h800, 12'h7FF, 1, SAMPLE_MAX);
        send_item(acws_pkg::OP_CONV, 12'h000, 12'h000, 12'h000, 12'h000);
        send_item(acws_pkg::OP_CONV, 12'h000, 12'h000, 12'hFFF, 12'h001);
        send_item(acws_pkg::OP_CONV, 12'h7FF, 12'h801, 12'h000, 12'h000);
        send_item(acws_pkg::OP_CHECK, 12'h000, 12'h000, 12'h000, 12'h000);
        send_item(acws_pkg::OP_CONV, 12'h000, 12'h000, 12'h000, 12'h000);
        send_item(acws_pkg::OP_CONV, 12'h000, 12'h000, 12'hFFE, 12'h000);
        send_item(acws_pkg::OP_CONV, 12'h7FE, 12'h800, 12'h000, 12'h000);
        send_item(acws_pkg::OP_CHECK, 12'h000, 12'h000, 12'h000, 12'h000);
    endtask

    task automatic test_random_traffic(input int sender_idle, input int receiver_idle);
        int sent;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        for (int set = 0; set < LIMIT_SETS; set++) begin
            drain_results();
            if (set == 0) begin
                load_limits(0, 0, 0, 0);
            end else if (set == 1) begin
                load_limits(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
            end else begin
                load_limits($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                            $urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX));
            end
            sent = 0;
            while (sent < ITEMS_PER_SET) begin
                if ($urandom_range(0, 99) < 15) begin
                    // stray request, may break a running measurement sequence
                    send_item(logic'($urandom_range(0, 1)), any_sample(), any_sample(),
                              any_sample(), any_sample());
                    sent++;
                end else begin
                    while (seq_phase != acws_pkg::PH_DONE) begin
                        case (seq_phase)
                            acws_pkg::PH_DARK: begin
                                send_item(acws_pkg::OP_CONV, any_sample(), any_sample(),
                                          any_sample(), any_sample());
                            end
                            acws_pkg::PH_SIDE: begin
                                send_item(acws_pkg::OP_CONV, any_sample(), any_sample(),
                                          pick_sample(dark_lvl[2], lim_side_right),
                                          pick_sample(dark_lvl[3], lim_side_left));
                            end
                            default: begin
                                send_item(acws_pkg::OP_CONV,
                                          pick_sample(dark_lvl[0], lim_front_right),
                                          pick_sample(dark_lvl[1], lim_front_left),
                                          any_sample(), any_sample());
                            end
                        endcase
                        sent++;
                    end
                    send_item(acws_pkg::OP_CHECK, any_sample(), any_sample(),
                              any_sample(), any_sample());
                    sent++;
                end
            end
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : reading_check
        acws_pkg::t_result got;
        acws_pkg::t_result want;
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tuser, o_m_axis_tdata[acws_pkg::OUT_BITS-1:0]};
            if (pending_readings.size() == 0) begin
                $error("unexpected result, nothing pending");
                error_count++;
            end else begin
                want = pending_readings.pop_front();
                check_field("phase_now", int'(want.phase_now), int'(got.phase_now));
                check_field("emitter_drive", int'(want.emitter_drive), int'(got.emitter_drive));
                check_field("front_left_value", int'(want.front_left_value),
                            int'(got.front_left_value));
                check_field("front_right_value", int'(want.front_right_value),
                            int'(got.front_right_value));
                check_field("side_left_value", int'(want.side_left_value),
                            int'(got.side_left_value));
                check_field("side_right_value", int'(want.side_right_value),
                            int'(got.side_right_value));
                check_field("wall_flags", int'(want.wall_flags), int'(got.wall_flags));
                check_field("wall_map", int'(want.wall_map), int'(got.wall_map));
                check_field("side_left_change", int'(want.side_left_change),
                            int'(got.side_left_change));
                check_field("side_right_change", int'(want.side_right_change),
                            int'(got.side_right_change));
                check_field("updated", int'(want.updated), int'(got.updated));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $error("no request or result moved for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 36;
        recv_idle_pct = 60;
        test_ignored_items();
        test_value_extremes();
        test_limit_boundaries();
        test_random_traffic(36, 60);
        test_random_traffic(60, 36);
        test_random_traffic(0, 0);
        drain_results();
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+src
src/acws_pkg.sv
src/acws_in_reg.sv
src/acws_core.sv
src/acws_out_reg.sv
src/ambient_cancelled_wall_sensor_sequencer.sv
tb/tb_ambient_cancelled_wall_sensor_sequencer.sv
